// File: rtl/core/tcsum_pkg.sv
package tcsum_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_ADDR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_UDP  = 2'd2;

  localparam logic [WORD_W-1:0] PROTO_UDP = 16'h0011;
  localparam logic [WORD_W-1:0] PROTO_TCP = 16'h0006;

  localparam logic [WORD_W-1:0] CK_OFF_UDP = 16'd6;
  localparam logic [WORD_W-1:0] CK_OFF_TCP = 16'd16;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t sum;
    word_t len;
  } fin_t;

  function automatic word_t oc_add(input word_t a, input word_t b);
    logic [WORD_W:0] s;
    logic [WORD_W:0] f;
    begin
      s = {1'b0, a} + {1'b0, b};
      f = {1'b0, s[WORD_W-1:0]} + {{WORD_W{1'b0}}, s[WORD_W]};
      oc_add = f[WORD_W-1:0];
    end
  endfunction

endpackage

// File: rtl/core/tcsum_accum.sv
module tcsum_accum #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    beat_valid,
  output logic                    beat_ready,
  input  logic [7:0]              data_byte,
  input  logic                    last,
  input  logic                    use_udp,
  output logic                    fin_valid,
  input  logic                    fin_ready,
  output tcsum_pkg::fin_t         fin
);
  import tcsum_pkg::*;

  localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};

  word_t                  sum_r;
  logic [LENGTH_BITS-1:0] count_r;
  logic [DATA_W-1:0]      high_r;
  logic                   odd_r;
  logic                   fin_valid_r;
  fin_t                   fin_r;

  logic                   take;
  logic                   below_max;
  word_t                  pos;
  word_t                  ck_off;
  logic [DATA_W-1:0]      b;
  word_t                  sum_nxt;
  logic [LENGTH_BITS-1:0] count_nxt;

  assign beat_ready = !fin_valid_r || fin_ready;
  assign take       = beat_valid && beat_ready;
  assign fin_valid  = fin_valid_r;
  assign fin        = fin_r;

  always_comb begin
    below_max = (count_r != COUNT_MAX);
    pos       = WORD_W'(count_r);
    ck_off    = use_udp ? CK_OFF_UDP : CK_OFF_TCP;
    b         = data_byte;
    if (below_max && (pos == ck_off || pos == ck_off + 16'd1)) begin
      b = '0;
    end
    sum_nxt = sum_r;
    if (odd_r) begin
      sum_nxt = oc_add(sum_r, {high_r, b});
    end else if (last) begin
      sum_nxt = oc_add(sum_r, {b, 8'h00});
    end
    count_nxt = below_max ? count_r + 1'b1 : count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      count_r     <= '0;
      high_r      <= '0;
      odd_r       <= 1'b0;
      fin_valid_r <= 1'b0;
    end else begin
      if (fin_valid_r && fin_ready) begin
        fin_valid_r <= 1'b0;
      end
      if (take) begin
        if (last) begin
          sum_r       <= '0;
          count_r     <= '0;
          high_r      <= '0;
          odd_r       <= 1'b0;
          fin_valid_r <= 1'b1;
        end else begin
          sum_r   <= sum_nxt;
          count_r <= count_nxt;
          high_r  <= b;
          odd_r   <= !odd_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && last) begin
      fin_r.sum <= sum_nxt;
      fin_r.len <= WORD_W'(count_nxt);
    end
  end

endmodule

// File: rtl/core/transport_checksum_pseudoheader_unit.sv
// Transport checksum unit for UDP or TCP segments over IPv4.
// Segment bytes enter on the in_ channel, one beat per byte, header first,
// with in_last on the final byte. The checksum field of the segment is
// summed as zero. On the final byte the unit adds the pseudo-header built
// from the cfg_ registers and delivers one out_ beat holding the finished
// checksum and the counted segment length.
// Throughput is one byte per cycle while in_ready is high: the running sum is
// at most a single 16-bit one's-complement add per beat. After its final byte
// is accepted, one stage closes the segment sum and the output register then
// adds the pseudo-header sum and the length.
// If the receiver stalls, the output register and one finished segment sum
// hold, and in_ready drops until the output is taken.
// Configuration registers are written through cfg_we, only while no segment
// is in flight; the block leaves that to the user. Synchronous reset clears
// the registers, the running sum, the byte count and all valid flags.
module transport_checksum_pseudoheader_unit #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [15:0]                    out_checksum,
  output logic [15:0]                    out_segment_length,
  input  logic                           cfg_we,
  input  logic [tcsum_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata
);
  import tcsum_pkg::*;

  logic [ADDR_W-1:0] src_addr_r;
  logic [ADDR_W-1:0] dst_addr_r;
  logic              use_udp_r;
  word_t             pseudo_r;
  word_t             pseudo_nxt;

  logic              fin_valid;
  logic              fin_ready;
  fin_t              fin;

  logic              out_valid_r;
  word_t             checksum_r;
  word_t             length_r;
  word_t             total;

  tcsum_accum #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat_valid(in_valid),
    .beat_ready(in_ready),
    .data_byte (in_data_byte),
    .last      (in_last),
    .use_udp   (use_udp_r),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin       (fin)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_addr_r <= '0;
      dst_addr_r <= '0;
      use_udp_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SRC_ADDR: src_addr_r <= cfg_wdata;
        CFG_DST_ADDR: dst_addr_r <= cfg_wdata;
        CFG_USE_UDP:  use_udp_r  <= cfg_wdata[0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    pseudo_nxt = oc_add(src_addr_r[31:16], src_addr_r[15:0]);
    pseudo_nxt = oc_add(pseudo_nxt, oc_add(dst_addr_r[31:16], dst_addr_r[15:0]));
    pseudo_nxt = oc_add(pseudo_nxt, use_udp_r ? PROTO_UDP : PROTO_TCP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pseudo_r <= '0;
    end else begin
      pseudo_r <= pseudo_nxt;
    end
  end

  assign fin_ready = !out_valid_r || out_ready;
  assign total     = oc_add(oc_add(fin.sum, pseudo_r), fin.len);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_ready) begin
      out_valid_r <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid && fin_ready) begin
      checksum_r <= ~total;
      length_r   <= fin.len;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_checksum       = checksum_r;
  assign out_segment_length = length_r;

endmodule
